/* src/mlsq_pkg.sv */
// Shared types and constants for the multi-list stack and queue manager.
package mlsq_pkg;

  localparam int NUM_LISTS  = 16;
  localparam int POOL_DEPTH = 256;
  localparam int WORD_WIDTH = 32;

  localparam int ID_W    = 4;
  localparam int LIST_W  = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int NODE_W  = $clog2(POOL_DEPTH);
  localparam int COUNT_W = $clog2(POOL_DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 3;

  localparam int IN_BITS    = 2 + ID_W + 1 + VALUE_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = STAT_W + VALUE_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [1:0] CMD_CREATE = 2'd0;
  localparam logic [1:0] CMD_PUSH   = 2'd1;
  localparam logic [1:0] CMD_POP    = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 3'd0,
    STAT_EXISTS  = 3'd1,
    STAT_MISSING = 3'd2,
    STAT_EMPTY   = 3'd3,
    STAT_FULL    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LINK
  } state_t;

  typedef struct packed {
    logic                  stack;
    logic [NODE_W-1:0]     first;
    logic [NODE_W-1:0]     last;
    logic [COUNT_W-1:0]    cnt;
  } list_entry_t;

  typedef struct packed {
    logic                  rd_en;
    logic [NODE_W-1:0]     rd_addr;
    logic                  we_word;
    logic                  we_link;
    logic [NODE_W-1:0]     wr_addr;
    logic [WORD_WIDTH-1:0] wr_word;
    logic [NODE_W-1:0]     wr_link;
  } node_req_t;

  typedef struct packed {
    logic [WORD_WIDTH-1:0] word;
    logic [NODE_W-1:0]     link;
  } node_rsp_t;

endpackage

/* src/multi_list_stack_queue_manager.sv */
// Top level: command sequencer, per-list table, free chain state and result register.
// An accepted command reads the node memories on acceptance (ST_IDLE) and writes them back in
// ST_EXEC once the result register is free; a push onto a non-empty queue adds ST_LINK,
// relinking the old tail through the single link memory write port.
// The result is loaded into the master-side result register as ST_EXEC completes.
// Synchronous reset empties all lists and restores the free chain with no clearing pass.
module multi_list_stack_queue_manager (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // cmd[1:0], list_id[5:2], make_stack[6], push_value[38:7], zero pad above
  input  logic [mlsq_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status[2:0], popped_value[34:3], zero pad above
  output logic [mlsq_pkg::OUT_DATA_W-1:0] m_tdata,
  // popped_valid[0]
  output logic                            m_tuser
);

  mlsq_pkg::state_t                     state, state_next;
  mlsq_pkg::node_req_t                  req;
  mlsq_pkg::node_rsp_t                  rsp;

  logic [mlsq_pkg::NUM_LISTS-1:0]       list_exists;
  mlsq_pkg::list_entry_t                list_tab [mlsq_pkg::NUM_LISTS];

  logic [1:0]                           cmd_q;
  logic [mlsq_pkg::ID_W-1:0]            id_q;
  logic                                 stack_q;
  logic [mlsq_pkg::WORD_WIDTH-1:0]      value_q;

  logic [mlsq_pkg::NODE_W-1:0]          free_head, free_head_next;
  logic [mlsq_pkg::COUNT_W-1:0]         free_count, free_count_next;
  logic [mlsq_pkg::NODE_W-1:0]          pend_addr, pend_addr_next;
  logic [mlsq_pkg::NODE_W-1:0]          pend_link, pend_link_next;

  logic                                 accept;
  logic [1:0]                           in_cmd;
  logic [mlsq_pkg::ID_W-1:0]            in_id;
  logic [mlsq_pkg::LIST_W-1:0]          in_idx;
  logic [mlsq_pkg::LIST_W-1:0]          idx_q;
  logic                                 id_ok;
  mlsq_pkg::list_entry_t                cur;
  mlsq_pkg::list_entry_t                tab_entry;
  logic                                 tab_we;
  logic                                 exists_set;
  logic                                 out_free;
  logic                                 res_load;
  mlsq_pkg::status_t                    res_status;
  logic [mlsq_pkg::VALUE_W-1:0]         res_word;
  logic                                 res_valid;

  assign in_cmd   = s_tdata[1:0];
  assign in_id    = s_tdata[5:2];
  assign in_idx   = in_id[mlsq_pkg::LIST_W-1:0];
  assign idx_q    = id_q[mlsq_pkg::LIST_W-1:0];
  assign s_tready = (state == mlsq_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign id_ok    = int'(id_q) < mlsq_pkg::NUM_LISTS;
  assign cur      = list_tab[idx_q];
  assign out_free = !m_tvalid || m_tready;

  mlsq_node_store u_nodes (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlsq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    req             = '0;
    tab_we          = 1'b0;
    tab_entry       = cur;
    exists_set      = 1'b0;
    free_head_next  = free_head;
    free_count_next = free_count;
    pend_addr_next  = pend_addr;
    pend_link_next  = pend_link;
    res_load        = 1'b0;
    res_status      = mlsq_pkg::STAT_OK;
    res_word        = '0;
    res_valid       = 1'b0;
    unique case (state)
      mlsq_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          req.rd_en   = 1'b1;
          req.rd_addr = (in_cmd == mlsq_pkg::CMD_PUSH) ? free_head : list_tab[in_idx].first;
          state_next  = mlsq_pkg::ST_EXEC;
        end
      end
      mlsq_pkg::ST_EXEC: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = mlsq_pkg::ST_IDLE;
          priority if (!id_ok) begin
            res_status = mlsq_pkg::STAT_MISSING;
          end else if (cmd_q == mlsq_pkg::CMD_CREATE) begin
            if (list_exists[idx_q]) begin
              res_status = mlsq_pkg::STAT_EXISTS;
            end else begin
              exists_set = 1'b1;
              tab_we     = 1'b1;
              tab_entry  = '{stack: stack_q, first: '0, last: '0, cnt: '0};
            end
          end else if (!list_exists[idx_q]) begin
            res_status = mlsq_pkg::STAT_MISSING;
          end else if (cmd_q == mlsq_pkg::CMD_PUSH) begin
            if (free_count == '0) begin
              res_status = mlsq_pkg::STAT_FULL;
            end else begin
              req.we_word     = 1'b1;
              req.we_link     = 1'b1;
              req.wr_addr     = free_head;
              req.wr_word     = value_q;
              req.wr_link     = '0;
              free_head_next  = rsp.link;
              free_count_next = free_count - mlsq_pkg::COUNT_W'(1);
              tab_we          = 1'b1;
              tab_entry.cnt   = cur.cnt + mlsq_pkg::COUNT_W'(1);
              if (cur.cnt == '0) begin
                tab_entry.first = free_head;
                tab_entry.last  = free_head;
              end else if (cur.stack) begin
                req.wr_link     = cur.first;
                tab_entry.first = free_head;
              end else begin
                tab_entry.last = free_head;
                pend_addr_next = cur.last;
                pend_link_next = free_head;
                state_next     = mlsq_pkg::ST_LINK;
              end
            end
          end else begin
            if (cur.cnt == '0) begin
              res_status = mlsq_pkg::STAT_EMPTY;
            end else begin
              res_word        = mlsq_pkg::VALUE_W'(rsp.word);
              res_valid       = 1'b1;
              req.we_link     = 1'b1;
              req.wr_addr     = cur.first;
              req.wr_link     = free_head;
              free_head_next  = cur.first;
              free_count_next = free_count + mlsq_pkg::COUNT_W'(1);
              tab_we          = 1'b1;
              tab_entry.cnt   = cur.cnt - mlsq_pkg::COUNT_W'(1);
              if (cur.cnt == mlsq_pkg::COUNT_W'(1)) begin
                tab_entry.first = '0;
                tab_entry.last  = '0;
              end else begin
                tab_entry.first = rsp.link;
              end
            end
          end
        end
      end
      mlsq_pkg::ST_LINK: begin
        req.we_link = 1'b1;
        req.wr_addr = pend_addr;
        req.wr_link = pend_link;
        state_next  = mlsq_pkg::ST_IDLE;
      end
      default: begin
        state_next = mlsq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= in_cmd;
      id_q    <= in_id;
      stack_q <= s_tdata[6];
      value_q <= mlsq_pkg::WORD_WIDTH'(s_tdata[38:7]);
    end
    pend_addr <= pend_addr_next;
    pend_link <= pend_link_next;
    if (tab_we) begin
      list_tab[idx_q] <= tab_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      list_exists <= '0;
      free_head   <= '0;
      free_count  <= mlsq_pkg::COUNT_W'(mlsq_pkg::POOL_DEPTH);
    end else begin
      if (exists_set) begin
        list_exists[idx_q] <= 1'b1;
      end
      free_head  <= free_head_next;
      free_count <= free_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      m_tdata <= {(mlsq_pkg::OUT_DATA_W - mlsq_pkg::OUT_BITS)'(0), res_word, res_status};
      m_tuser <= res_valid;
    end
  end

endmodule

/* src/mlsq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module mlsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/mlsq_node_store.sv */
// Node pool: word and link memories, with the initial free chain for unwritten links.
module mlsq_node_store (
  input  logic               clk,
  input  logic               rst,
  input  mlsq_pkg::node_req_t req,
  output mlsq_pkg::node_rsp_t rsp
);

  logic [mlsq_pkg::POOL_DEPTH-1:0] link_vld;
  logic                            vld_q;
  logic [mlsq_pkg::NODE_W-1:0]     addr_q;
  logic [mlsq_pkg::NODE_W-1:0]     link_ram;
  logic [mlsq_pkg::NODE_W-1:0]     link_dflt;

  mlsq_ram #(.WIDTH(mlsq_pkg::WORD_WIDTH), .DEPTH(mlsq_pkg::POOL_DEPTH)) u_word_ram (
    .clk   (clk),
    .we    (req.we_word),
    .waddr (req.wr_addr),
    .wdata (req.wr_word),
    .re    (req.rd_en),
    .raddr (req.rd_addr),
    .rdata (rsp.word)
  );

  mlsq_ram #(.WIDTH(mlsq_pkg::NODE_W), .DEPTH(mlsq_pkg::POOL_DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (req.we_link),
    .waddr (req.wr_addr),
    .wdata (req.wr_link),
    .re    (req.rd_en),
    .raddr (req.rd_addr),
    .rdata (link_ram)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      link_vld <= '0;
    end else if (req.we_link) begin
      link_vld[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      vld_q  <= link_vld[req.rd_addr];
      addr_q <= req.rd_addr;
    end
  end

  // A link never written still holds the reset free chain: each node points to the next.
  assign link_dflt = (addr_q == mlsq_pkg::NODE_W'(mlsq_pkg::POOL_DEPTH - 1)) ?
                     '0 : addr_q + mlsq_pkg::NODE_W'(1);
  assign rsp.link  = vld_q ? link_ram : link_dflt;

endmodule

/* src/mlsq_checker.sv */
// Port-level checker for the multi-list stack and queue manager, bound to the top level.
module mlsq_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [mlsq_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [mlsq_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tuser
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("new transfer taken while a command is in progress");

  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[2:0] == mlsq_pkg::STAT_OK)
    else $error("popped word given with a failing status");

  a_word_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[34:3] == '0)
    else $error("nonzero word without a popped word");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  logic unused_in;
  assign unused_in = ^s_tdata;

endmodule

bind multi_list_stack_queue_manager mlsq_checker u_mlsq_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

/* tb/sv/tb_top.sv */
// Self-checking testbench for the multi-list stack and queue manager.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mlsq_pkg::*;

  localparam logic [1:0] CMD_POP_ALIAS = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_AT        = 300;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 10;

  typedef enum {PHASE_MIXED, PHASE_FILL, PHASE_DRAIN} phase_t;

  typedef struct {
    logic [1:0]         cmd;
    logic [ID_W-1:0]    id;
    logic               stack;
    logic [VALUE_W-1:0] value;
  } command_t;

  typedef struct {
    status_t            status;
    logic [VALUE_W-1:0] value;
    logic               valid;
  } response_t;

  class list_pool_scoreboard;
    bit                    exists[NUM_LISTS];
    bit                    is_stack[NUM_LISTS];
    logic [NODE_W-1:0]     head[NUM_LISTS];
    logic [NODE_W-1:0]     tail[NUM_LISTS];
    int unsigned           depth[NUM_LISTS];
    logic [WORD_WIDTH-1:0] node_word[POOL_DEPTH];
    logic [NODE_W-1:0]     node_link[POOL_DEPTH];
    logic [NODE_W-1:0]     free_head;
    int unsigned           free_count;
    int unsigned           full_hits;
    int unsigned           errors;
    response_t             expected_q[$];

    function new();
      for (int i = 0; i < NUM_LISTS; i++) begin
        exists[i]   = 1'b0;
        is_stack[i] = 1'b0;
        head[i]     = '0;
        tail[i]     = '0;
        depth[i]    = 0;
      end
      for (int i = 0; i < POOL_DEPTH; i++) begin
        node_word[i] = '0;
        node_link[i] = NODE_W'((i + 1) % POOL_DEPTH);
      end
      free_head  = '0;
      free_count = POOL_DEPTH;
      full_hits  = 0;
      errors     = 0;
    endfunction

    function void note_command(command_t c);
      response_t         r;
      logic [NODE_W-1:0] n;
      int                id;
      id       = int'(c.id);
      r.status = STAT_OK;
      r.value  = '0;
      r.valid  = 1'b0;
      if (id >= NUM_LISTS) begin
        r.status = STAT_MISSING;
      end else if (c.cmd == CMD_CREATE) begin
        if (exists[id]) begin
          r.status = STAT_EXISTS;
        end else begin
          exists[id]   = 1'b1;
          is_stack[id] = c.stack;
          head[id]     = '0;
          tail[id]     = '0;
          depth[id]    = 0;
        end
      end else if (!exists[id]) begin
        r.status = STAT_MISSING;
      end else if (c.cmd == CMD_PUSH) begin
        if (free_count == 0) begin
          r.status = STAT_FULL;
          full_hits++;
        end else begin
          n            = free_head;
          free_head    = node_link[n];
          free_count--;
          node_word[n] = c.value[WORD_WIDTH-1:0];
          if (depth[id] == 0) begin
            node_link[n] = '0;
            head[id]     = n;
            tail[id]     = n;
          end else if (is_stack[id]) begin
            node_link[n] = head[id];
            head[id]     = n;
          end else begin
            node_link[n]        = '0;
            node_link[tail[id]] = n;
            tail[id]            = n;
          end
          depth[id]++;
        end
      end else begin
        if (depth[id] == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          n        = head[id];
          r.value  = VALUE_W'(node_word[n]);
          r.valid  = 1'b1;
          head[id] = node_link[n];
          depth[id]--;
          if (depth[id] == 0) begin
            head[id] = '0;
            tail[id] = '0;
          end
          node_link[n] = free_head;
          free_head    = n;
          free_count++;
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_response(logic [STAT_W-1:0] status, logic [VALUE_W-1:0] value,
                                 logic valid);
      response_t e;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: status %0d value %h valid %b",
                 $time, status, value, valid);
        return;
      end
      e = expected_q.pop_front();
      if (status !== e.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, e.status, status);
      end
      if (value !== e.value) begin
        errors++;
        $display("%0t: popped_value mismatch: expected %h, actual %h", $time, e.value, value);
      end
      if (valid !== e.valid) begin
        errors++;
        $display("%0t: popped_valid mismatch: expected %b, actual %b", $time, e.valid, valid);
      end
    endfunction

    function int pending_count();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  list_pool_scoreboard sb;
  int                  tx_count;
  int                  rx_count;
  int                  stall_cycles;

  multi_list_stack_queue_manager i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("multi_list_stack_queue_manager regression: fail");
      $finish;
    end
  end

  task automatic send_command(command_t c);
    int gap;
    if (((tx_count / 50) % 5) == 4) begin
      gap = 0;
    end else begin
      gap = $urandom_range(0, 4);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_W'({c.value, c.stack, c.id, c.cmd});
    do @(posedge clk); while (!s_tready);
    sb.note_command(c);
    tx_count++;
  endtask

  task automatic send_fields(logic [1:0] cmd, int id, logic stack, logic [VALUE_W-1:0] value);
    command_t c;
    c.cmd   = cmd;
    c.id    = ID_W'(id);
    c.stack = stack;
    c.value = value;
    send_command(c);
  endtask

  // The long hold-off lets the block fill up so that its input stalls.
  task automatic drain_results();
    int gap;
    forever begin
      if (rx_count == HOLD_AT) begin
        gap = HOLD_CYCLES;
      end else if (((rx_count / 40) % 5) == 2) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 4);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_response(m_tdata[STAT_W-1:0], m_tdata[STAT_W +: VALUE_W], m_tuser);
      rx_count++;
    end
  endtask

  function automatic logic [ID_W-1:0] pick_list(int bias, bit need_entries);
    int live[$];
    for (int i = 0; i < NUM_LISTS; i++) begin
      if (sb.exists[i] && (!need_entries || sb.depth[i] > 0)) live.push_back(i);
    end
    if (live.size() > 0 && $urandom_range(0, 99) < bias) begin
      return ID_W'(live[$urandom_range(0, live.size() - 1)]);
    end
    return ID_W'($urandom_range(0, (1 << ID_W) - 1));
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic command_t random_command(phase_t ph);
    command_t c;
    int       roll;
    int       create_pct;
    int       push_pct;
    int       bias;
    roll = $urandom_range(0, 99);
    case (ph)
      PHASE_FILL: begin
        create_pct = 8;
        push_pct   = 82;
        bias       = 90;
      end
      PHASE_DRAIN: begin
        create_pct = 8;
        push_pct   = 7;
        bias       = 90;
      end
      default: begin
        create_pct = 25;
        push_pct   = 40;
        bias       = 60;
      end
    endcase
    c.stack = 1'($urandom_range(0, 1));
    c.value = random_value();
    if (roll < create_pct) begin
      c.cmd = CMD_CREATE;
      c.id  = pick_list(30, 1'b0);
    end else if (roll < create_pct + push_pct) begin
      c.cmd = CMD_PUSH;
      c.id  = pick_list(bias, 1'b0);
    end else begin
      c.cmd = ($urandom_range(0, 3) == 0) ? CMD_POP_ALIAS : CMD_POP;
      c.id  = pick_list(bias, ph == PHASE_DRAIN);
    end
    return c;
  endfunction

  task automatic run_mixed(int count);
    repeat (count) send_command(random_command(PHASE_MIXED));
  endtask

  task automatic run_fill();
    int unsigned start_hits;
    int          n;
    start_hits = sb.full_hits;
    n          = 0;
    while ((sb.full_hits - start_hits) < 12 && n < 700) begin
      send_command(random_command(PHASE_FILL));
      n++;
    end
  endtask

  task automatic run_drain();
    int n;
    n = 0;
    while (sb.free_count < POOL_DEPTH && n < 700) begin
      send_command(random_command(PHASE_DRAIN));
      n++;
    end
    repeat (20) send_command(random_command(PHASE_DRAIN));
  endtask

  initial begin
    sb           = new();
    tx_count     = 0;
    rx_count     = 0;
    stall_cycles = 0;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    m_tready     = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    fork
      drain_results();
    join_none

    send_fields(CMD_POP, 5, 1'b0, '0);
    send_fields(CMD_PUSH, 5, 1'b1, 32'hdead_beef);
    send_fields(CMD_CREATE, 0, 1'b1, '0);
    send_fields(CMD_CREATE, 0, 1'b0, '1);
    send_fields(CMD_CREATE, 1, 1'b0, '0);
    send_fields(CMD_POP, 0, 1'b0, '0);
    send_fields(CMD_POP_ALIAS, 1, 1'b1, '0);
    send_fields(CMD_PUSH, 0, 1'b0, '0);
    send_fields(CMD_PUSH, 0, 1'b0, '1);
    send_fields(CMD_PUSH, 0, 1'b1, 32'h1234_5678);
    send_fields(CMD_POP, 0, 1'b0, '0);
    send_fields(CMD_POP, 0, 1'b0, '0);
    send_fields(CMD_PUSH, 1, 1'b0, 32'ha5a5_a5a5);
    send_fields(CMD_PUSH, 1, 1'b1, '1);
    send_fields(CMD_PUSH, 1, 1'b0, '0);
    send_fields(CMD_POP_ALIAS, 1, 1'b0, '0);
    send_fields(CMD_POP, 1, 1'b0, '0);
    send_fields(CMD_POP, 1, 1'b1, '0);
    send_fields(CMD_POP, 1, 1'b0, '0);
    send_fields(CMD_CREATE, 15, 1'b1, '0);
    send_fields(CMD_PUSH, 15, 1'b0, 32'h8000_0000);
    send_fields(CMD_POP_ALIAS, 15, 1'b0, '0);
    send_fields(CMD_PUSH, 15, 1'b0, 32'h0000_0001);
    send_fields(CMD_CREATE, 14, 1'b0, '0);

    run_mixed(200);
    run_fill();
    run_drain();
    run_fill();
    run_drain();
    run_mixed(200);

    s_tvalid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("multi_list_stack_queue_manager regression: pass");
    end else begin
      $display("multi_list_stack_queue_manager regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
src/mlsq_pkg.sv
src/mlsq_ram.sv
src/mlsq_node_store.sv
src/multi_list_stack_queue_manager.sv
src/mlsq_checker.sv
tb/sv/tb_top.sv
